// ----- sv/lams_pkg.sv -----
// Shared types and constants of the line/address map search block.
package lams_pkg;

  localparam int unsigned MaxEntries = 4096;
  localparam int unsigned MaxPages   = 256;

  localparam int unsigned PageW     = 8;
  localparam int unsigned PageCntW  = 9;
  localparam int unsigned ValW      = 24;
  localparam int unsigned EntryIdxW = $clog2(MaxEntries);
  localparam int unsigned EntryCntW = EntryIdxW + 1;

  typedef enum logic [1:0] {
    ReqAppend = 2'd0,
    ReqLine   = 2'd1,
    ReqAddr   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StBadPage  = 2'd2,
    StRefused  = 2'd3
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic [PageW-1:0]  page;
    logic [ValW-1:0]   line;
    logic [ValW-1:0]   addr;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [ValW-1:0]  value;
  } rsp_t;

  typedef struct packed {
    logic [ValW-1:0] line;
    logic [ValW-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic [EntryIdxW-1:0] first;
    logic [EntryCntW-1:0] count;
  } page_info_t;

  localparam int unsigned EntryW    = $bits(entry_t);
  localparam int unsigned PageInfoW = $bits(page_info_t);

endpackage

// ----- sv/lams_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lams_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/line_address_map_search.sv -----
// Top level: per-page (line, address) tables with binary-search lookup.
//
//   channel   signals                         handshake
//   -------   -----------------------------   ---------------------------------
//   request   start, busy, req_i              taken when start high, busy low
//   result    done_o, rsp_o                   one-cycle strobe, cannot be held off
//   config    cfg_valid_i, cfg_ready_o,       written when valid and ready high
//             cfg_data_i
//
// Append, bad page, empty page and unused requests strobe from the page state SPage.
// A search makes p probes, one per cycle on the entry memory read port (up to 13 for
// 4096 entries), then strobes from SFinal, or straight from SProbe when it misses.
// Busy falls as the strobe rises, and a new request is taken only once it has fallen.
// Reset empties all pages through per-page valid bits; no clearing pass is needed.
// The receiver cannot stall the block; busy is the only back-pressure.
module line_address_map_search
  import lams_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  output logic                done_o,
  output rsp_t                rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PageCntW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    SIdle,
    SPage,
    SProbe,
    SFinal
  } state_e;

  state_e                state_q, state_d;
  req_t                  req_q, req_d;
  logic [EntryCntW-1:0]  base_q, base_d;
  logic [EntryCntW-1:0]  end_q, end_d;
  logic [EntryCntW-1:0]  lo_q, lo_d;
  logic [EntryCntW-1:0]  hi_q, hi_d;
  logic [EntryIdxW-1:0]  mid_q, mid_d;
  logic [EntryCntW-1:0]  total_q, total_d;
  logic [PageW-1:0]      last_q, last_d;
  logic [PageCntW-1:0]   pcount_q;
  logic [MaxPages-1:0]   page_vld_q, page_vld_d;
  logic                  done_q, done_d;
  rsp_t                  rsp_q, rsp_d;

  logic                  page_we;
  logic [PageW-1:0]      page_raddr;
  page_info_t            page_wdata;
  logic [PageInfoW-1:0]  page_rdata;
  page_info_t            page_rd;

  logic                  entry_we;
  logic [EntryIdxW-1:0]  entry_raddr;
  entry_t                entry_wdata;
  logic [EntryW-1:0]     entry_rdata;
  entry_t                entry_rd;

  logic [EntryCntW-1:0]  cnt;
  logic [EntryCntW:0]    sum_setup, sum_right, sum_left;
  logic [EntryCntW-1:0]  mid_ext, mid_p1, lo_fin;
  logic [ValW-1:0]       key;
  logic                  by_line, go_right, cont_r, cont_l, miss;

  lams_ram #(
    .Width(PageInfoW),
    .Depth(MaxPages)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (page_we),
    .waddr_i(req_q.page),
    .wdata_i(page_wdata),
    .raddr_i(page_raddr),
    .rdata_o(page_rdata)
  );

  lams_ram #(
    .Width(EntryW),
    .Depth(MaxEntries)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (entry_we),
    .waddr_i(total_q[EntryIdxW-1:0]),
    .wdata_i(entry_wdata),
    .raddr_i(entry_raddr),
    .rdata_o(entry_rdata)
  );

  assign page_rd  = page_info_t'(page_rdata);
  assign entry_rd = entry_t'(entry_rdata);
  assign cnt      = page_vld_q[req_q.page] ? page_rd.count : '0;

  assign by_line  = (req_q.req_type == ReqLine);
  assign key      = by_line ? req_q.line : req_q.addr;
  assign go_right = by_line ? (entry_rd.line < key) : (entry_rd.addr <= key);

  // Both possible next midpoints are formed from registers, so the compare
  // only has to pick one of them.
  assign mid_ext   = {1'b0, mid_q};
  assign mid_p1    = mid_ext + EntryCntW'(1);
  assign cont_r    = (mid_p1 < hi_q);
  assign cont_l    = (lo_q < mid_ext);
  assign sum_right = {1'b0, mid_p1} + {1'b0, hi_q};
  assign sum_left  = {1'b0, lo_q} + {1'b0, mid_ext};
  assign sum_setup = {1'b0, EntryCntW'(page_rd.first)} + {1'b0, EntryCntW'(page_rd.first) + cnt};
  assign lo_fin    = go_right ? mid_p1 : lo_q;
  assign miss      = by_line ? (lo_fin >= end_q) : (lo_fin == base_q);

  assign page_wdata.first = (cnt == '0) ? total_q[EntryIdxW-1:0] : page_rd.first;
  assign page_wdata.count = cnt + EntryCntW'(1);
  assign entry_wdata.line = req_q.line;
  assign entry_wdata.addr = req_q.addr;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    base_d      = base_q;
    end_d       = end_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    total_d     = total_q;
    last_d      = last_q;
    page_vld_d  = page_vld_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    page_we     = 1'b0;
    entry_we    = 1'b0;
    page_raddr  = req_q.page;
    entry_raddr = mid_q;

    case (state_q)
      SIdle: begin
        if (start) begin
          req_d      = req_i;
          page_raddr = req_i.page;
          state_d    = SPage;
        end
      end

      SPage: begin
        rsp_d.value = '0;
        state_d     = SIdle;
        done_d      = 1'b1;
        case (req_q.req_type)
          ReqAppend: begin
            if (PageCntW'(req_q.page) >= PageCntW'(MaxPages)) begin
              rsp_d.status = StBadPage;
            end else if (total_q != '0 && req_q.page < last_q) begin
              rsp_d.status = StRefused;
            end else if (total_q >= EntryCntW'(MaxEntries)) begin
              rsp_d.status = StRefused;
            end else begin
              rsp_d.status           = StOk;
              page_we                = 1'b1;
              entry_we               = 1'b1;
              page_vld_d[req_q.page] = 1'b1;
              total_d                = total_q + EntryCntW'(1);
              last_d                 = req_q.page;
            end
          end
          ReqLine, ReqAddr: begin
            if (PageCntW'(req_q.page) >= pcount_q ||
                PageCntW'(req_q.page) >= PageCntW'(MaxPages)) begin
              rsp_d.status = StBadPage;
            end else if (cnt == '0) begin
              rsp_d.status = StNotFound;
            end else begin
              base_d      = EntryCntW'(page_rd.first);
              end_d       = EntryCntW'(page_rd.first) + cnt;
              lo_d        = EntryCntW'(page_rd.first);
              hi_d        = EntryCntW'(page_rd.first) + cnt;
              mid_d       = sum_setup[EntryIdxW:1];
              entry_raddr = sum_setup[EntryIdxW:1];
              done_d      = 1'b0;
              state_d     = SProbe;
            end
          end
          default: begin
            rsp_d.status = StNotFound;
          end
        endcase
      end

      SProbe: begin
        if (go_right && cont_r) begin
          lo_d        = mid_p1;
          mid_d       = sum_right[EntryIdxW:1];
          entry_raddr = sum_right[EntryIdxW:1];
        end else if (!go_right && cont_l) begin
          hi_d        = mid_ext;
          mid_d       = sum_left[EntryIdxW:1];
          entry_raddr = sum_left[EntryIdxW:1];
        end else if (miss) begin
          rsp_d.status = StNotFound;
          rsp_d.value  = '0;
          done_d       = 1'b1;
          state_d      = SIdle;
        end else begin
          // A line query reads the bound itself, an address query the entry before it.
          entry_raddr = by_line ? lo_fin[EntryIdxW-1:0]
                                : EntryIdxW'(lo_fin - EntryCntW'(1));
          state_d     = SFinal;
        end
      end

      SFinal: begin
        rsp_d.status = StOk;
        rsp_d.value  = by_line ? entry_rd.addr : entry_rd.line;
        done_d       = 1'b1;
        state_d      = SIdle;
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      req_q      <= '0;
      base_q     <= '0;
      end_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
      total_q    <= '0;
      last_q     <= '0;
      pcount_q   <= '0;
      page_vld_q <= '0;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      base_q     <= base_d;
      end_q      <= end_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      mid_q      <= mid_d;
      total_q    <= total_d;
      last_q     <= last_d;
      page_vld_q <= page_vld_d;
      done_q     <= done_d;
      rsp_q      <= rsp_d;
      if (cfg_valid_i) begin
        pcount_q <= cfg_data_i;
      end
    end
  end

  assign busy        = (state_q != SIdle);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

endmodule
